[rtl/mtnc_pkg.sv]
// Shared types and constants for the markup tag nesting checker.
// Holds character codes, error kinds and the stack control bundle.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mtnc_pkg;

  // Character codes that steer the tag parser
  localparam logic [7:0] ChOpen  = 8'h3C;
  localparam logic [7:0] ChClose = 8'h3E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNl    = 8'h0A;

  // Void element names, first byte in the low bits
  localparam logic [15:0] NameBr = 16'h7262;
  localparam logic [15:0] NameHr = 16'h7268;

  // Error kinds reported per line
  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrEmpty    = 3'd1,
    ErrMismatch = 3'd2,
    ErrLong     = 3'd3,
    ErrOverflow = 3'd4,
    ErrUnclosed = 3'd5
  } err_kind_e;

  // Stack shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

`default_nettype wire

[rtl/mtnc_stack_cell.sv]
// One entry of the shifting tag stack: a name and its length.
// Takes the entry above on a push and the entry below on a pop.
// Depends on mtnc_pkg for the control bundle.
`timescale 1ns / 1ps
`default_nettype none

module mtnc_stack_cell #(
  parameter int NameW = 64,
  parameter int LenW  = 4
) (
  input  wire logic                 clk_i,
  input  wire mtnc_pkg::stk_ctl_t   ctl_i,
  input  wire logic [NameW-1:0]     above_name_i,
  input  wire logic [LenW-1:0]      above_len_i,
  input  wire logic [NameW-1:0]     below_name_i,
  input  wire logic [LenW-1:0]      below_len_i,
  output logic      [NameW-1:0]     name_o,
  output logic      [LenW-1:0]      len_o
);

  logic [NameW-1:0] name_q, name_d;
  logic [LenW-1:0]  len_q, len_d;

  // Pick the neighbour to take over, or hold
  always_comb begin
    name_d = name_q;
    len_d  = len_q;
    if (ctl_i.push) begin
      name_d = above_name_i;
      len_d  = above_len_i;
    end else if (ctl_i.pop) begin
      name_d = below_name_i;
      len_d  = below_len_i;
    end
  end

  // Hold entry contents; stale entries are never compared
  always_ff @(posedge clk_i) begin
    name_q <= name_d;
    len_q  <= len_d;
  end

  assign name_o = name_q;
  assign len_o  = len_q;

endmodule

`default_nettype wire

[rtl/markup_tag_nesting_checker_core.sv]
// Markup tag nesting checker: byte parser, tag name buffer and a
// shifting chain of stack cells. Depends on mtnc_pkg and mtnc_stack_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_byte_i) takes one text
//   byte per cycle. A newline outside a tag, or any newline once an error
//   is recorded, finishes the line and yields one result item on the
//   output channel (out_valid_o / out_stall_i / verdict_o, error_kind_o,
//   open_count_o); all other bytes yield nothing.
//   The result is registered and appears in the cycle after its newline is accepted.
//   Throughput: one byte per cycle. Each byte does at most one compare
//   against the top cell and at most one shift of the cell chain.
//   The output register stalls the input only while a result is held and
//   out_stall_i is high; otherwise bytes flow on every cycle.
//   cfg_we_i / cfg_wdata_i write require_empty at any edge; write it only
//   while the block is idle.
//   Reset clears the parser, the line error, the stack count and
//   require_empty at once; stack cells are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_nesting_checker_core #(
  parameter int MAX_NAME_LEN = 8,
  parameter int STACK_DEPTH  = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            verdict_o,
  output logic [2:0]      error_kind_o,
  output logic [4:0]      open_count_o
);

  localparam int NameW = 8 * MAX_NAME_LEN;
  localparam int LenW  = $clog2(MAX_NAME_LEN + 1);
  localparam int CntW  = $clog2(STACK_DEPTH + 1);

  // Line state
  logic                     req_empty_q;
  logic                     in_name_q, in_name_d;
  logic                     closing_q, closing_d;
  logic [NameW-1:0]         name_q, name_d;
  logic [LenW-1:0]          len_q, len_d;
  logic [CntW-1:0]          count_q, count_d;
  mtnc_pkg::err_kind_e      err_q, err_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic                     verdict_q, verdict_d;
  mtnc_pkg::err_kind_e      kind_q, kind_d;
  logic [4:0]               open_q, open_d;

  logic                     accept;
  logic                     nl_fire;
  logic                     void_elem;
  logic                     top_match;
  logic [CntW-1:0]          count_sat;
  mtnc_pkg::stk_ctl_t       stk_ctl;

  logic [NameW-1:0]         cell_name [STACK_DEPTH];
  logic [LenW-1:0]          cell_len  [STACK_DEPTH];

  // Stall input only while a result waits downstream
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign nl_fire = (in_byte_i == mtnc_pkg::ChNl) &&
                   (!in_name_q || (err_q != mtnc_pkg::ErrNone));

  assign void_elem = (MAX_NAME_LEN >= 2) && (len_q == LenW'(2)) &&
                     ((name_q == NameW'(mtnc_pkg::NameBr)) ||
                      (name_q == NameW'(mtnc_pkg::NameHr)));

  assign top_match = (cell_name[0] == name_q) && (cell_len[0] == len_q);

  assign count_sat = (count_q > CntW'(31)) ? CntW'(31) : count_q;

  // Parse one byte: name capture, push/pop decisions and line result
  always_comb begin
    in_name_d   = in_name_q;
    closing_d   = closing_q;
    name_d      = name_q;
    len_d       = len_q;
    count_d     = count_q;
    err_d       = err_q;
    stk_ctl     = '0;
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;
    kind_d      = kind_q;
    open_d      = open_q;

    if (accept) begin
      if (nl_fire) begin
        kind_d = err_q;
        if (err_q == mtnc_pkg::ErrNone && req_empty_q && count_q != '0) begin
          kind_d = mtnc_pkg::ErrUnclosed;
        end
        verdict_d   = (kind_d != mtnc_pkg::ErrNone);
        open_d      = 5'(count_sat);
        out_valid_d = 1'b1;
        in_name_d   = 1'b0;
        closing_d   = 1'b0;
        name_d      = '0;
        len_d       = '0;
        count_d     = '0;
        err_d       = mtnc_pkg::ErrNone;
      end else if (err_q != mtnc_pkg::ErrNone) begin
        // drop bytes until the line ends
      end else if (!in_name_q) begin
        if (in_byte_i == mtnc_pkg::ChOpen) begin
          in_name_d = 1'b1;
          closing_d = 1'b0;
          name_d    = '0;
          len_d     = '0;
        end
      end else if (in_byte_i == mtnc_pkg::ChClose || in_byte_i == mtnc_pkg::ChSpace) begin
        if (closing_q) begin
          if (count_q == '0) begin
            err_d = mtnc_pkg::ErrEmpty;
          end else begin
            stk_ctl.pop = 1'b1;
            count_d     = count_q - CntW'(1);
            if (!top_match) begin
              err_d = mtnc_pkg::ErrMismatch;
            end
          end
        end else if (!void_elem) begin
          if (count_q >= CntW'(STACK_DEPTH)) begin
            err_d = mtnc_pkg::ErrOverflow;
          end else begin
            stk_ctl.push = 1'b1;
            count_d      = count_q + CntW'(1);
          end
        end
        in_name_d = 1'b0;
        closing_d = 1'b0;
        name_d    = '0;
        len_d     = '0;
      end else if (in_byte_i == mtnc_pkg::ChSlash && len_q == '0 && !closing_q) begin
        closing_d = 1'b1;
      end else if (len_q >= LenW'(MAX_NAME_LEN)) begin
        err_d = mtnc_pkg::ErrLong;
      end else begin
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
          if (len_q == LenW'(i)) begin
            name_d[8*i +: 8] = in_byte_i;
          end
        end
        len_d = len_q + LenW'(1);
      end
    end
  end

  // Advance control and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_empty_q <= 1'b0;
      in_name_q   <= 1'b0;
      closing_q   <= 1'b0;
      name_q      <= '0;
      len_q       <= '0;
      count_q     <= '0;
      err_q       <= mtnc_pkg::ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        req_empty_q <= cfg_wdata_i;
      end
      in_name_q   <= in_name_d;
      closing_q   <= closing_d;
      name_q      <= name_d;
      len_q       <= len_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    kind_q    <= kind_d;
    open_q    <= open_d;
  end

  // Chain of stack cells, cell 0 is the top of the stack
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [NameW-1:0] above_name, below_name;
    logic [LenW-1:0]  above_len, below_len;

    if (g == 0) begin : g_top
      assign above_name = name_q;
      assign above_len  = len_q;
    end else begin : g_mid
      assign above_name = cell_name[g-1];
      assign above_len  = cell_len[g-1];
    end

    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below_name = '0;
      assign below_len  = '0;
    end else begin : g_inner
      assign below_name = cell_name[g+1];
      assign below_len  = cell_len[g+1];
    end

    mtnc_stack_cell #(
      .NameW (NameW),
      .LenW  (LenW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (stk_ctl),
      .above_name_i (above_name),
      .above_len_i  (above_len),
      .below_name_i (below_name),
      .below_len_i  (below_len),
      .name_o       (cell_name[g]),
      .len_o        (cell_len[g])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign error_kind_o = kind_q;
  assign open_count_o = open_q;

endmodule

`default_nettype wire
